FILE: design/kdme_pkg.sv
package kdme_pkg;

  localparam int CFG_W   = 7;
  localparam int TILE_W  = 8;
  localparam int VALUE_W = 8;

  localparam logic [CFG_W-1:0] TILES_RESET = 7'd49;

  // register word indexes on the configuration port
  localparam logic REG_TILES = 1'b0;

  typedef enum logic [2:0] {
    KIND_TILE  = 3'd0,
    KIND_KNOWN = 3'd1,
    KIND_NEW   = 3'd2,
    KIND_BYTE  = 3'd3,
    KIND_FULL  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [TILE_W-1:0] tile;
    logic              restart;
  } in_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_TILE,
    ST_SRD,
    ST_SCMP,
    ST_KNOWN,
    ST_NEW,
    ST_BYTE,
    ST_FULL
  } state_t;

  typedef struct packed {
    logic  take;
    logic  mark;
    logic  tbl_rd;
    logic  idx_inc;
    logic  store;
    logic  emit;
    kind_t kind;
    logic  last;
    logic  byte_inc;
    logic  clr_mask;
  } cmd_t;

  typedef struct packed {
    logic capt;
    logic diff;
    logic fend;
    logic scan_end;
    logic hit;
    logic full;
    logic byte_last;
    logic out_free;
  } stat_t;

endpackage

FILE: design/kdme_ctrl.sv
module kdme_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  kdme_pkg::stat_t stat,
  output kdme_pkg::cmd_t  cmd
);

  kdme_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kdme_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = kdme_pkg::KIND_TILE;
    in_ready  = 1'b0;
    case (state_r)
      kdme_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = kdme_pkg::ST_LOOK;
        end
      end
      kdme_pkg::ST_LOOK: begin
        if (stat.capt) begin
          state_nxt = kdme_pkg::ST_IDLE;
        end else if (stat.diff) begin
          cmd.mark  = 1'b1;
          state_nxt = kdme_pkg::ST_TILE;
        end else if (stat.fend) begin
          state_nxt = kdme_pkg::ST_SRD;
        end else begin
          state_nxt = kdme_pkg::ST_IDLE;
        end
      end
      kdme_pkg::ST_TILE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = kdme_pkg::KIND_TILE;
          cmd.last  = !stat.fend;
          state_nxt = stat.fend ? kdme_pkg::ST_SRD : kdme_pkg::ST_IDLE;
        end
      end
      kdme_pkg::ST_SRD: begin
        if (stat.scan_end) begin
          state_nxt = stat.full ? kdme_pkg::ST_FULL : kdme_pkg::ST_NEW;
        end else begin
          cmd.tbl_rd = 1'b1;
          state_nxt  = kdme_pkg::ST_SCMP;
        end
      end
      kdme_pkg::ST_SCMP: begin
        if (stat.hit) begin
          state_nxt = kdme_pkg::ST_KNOWN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = kdme_pkg::ST_SRD;
        end
      end
      kdme_pkg::ST_KNOWN: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = kdme_pkg::KIND_KNOWN;
          cmd.last     = 1'b1;
          cmd.clr_mask = 1'b1;
          state_nxt    = kdme_pkg::ST_IDLE;
        end
      end
      kdme_pkg::ST_FULL: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = kdme_pkg::KIND_FULL;
          cmd.last     = 1'b1;
          cmd.clr_mask = 1'b1;
          state_nxt    = kdme_pkg::ST_IDLE;
        end
      end
      kdme_pkg::ST_NEW: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = kdme_pkg::KIND_NEW;
          cmd.store = 1'b1;
          state_nxt = kdme_pkg::ST_BYTE;
        end
      end
      kdme_pkg::ST_BYTE: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = kdme_pkg::KIND_BYTE;
          cmd.last     = stat.byte_last;
          cmd.byte_inc = 1'b1;
          if (stat.byte_last) begin
            cmd.clr_mask = 1'b1;
            state_nxt    = kdme_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = kdme_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/kdme_dp.sv
module kdme_dp #(
  parameter int MAX_TILES = 64,
  parameter int MAX_MASKS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kdme_pkg::in_t              in_data,
  input  logic [kdme_pkg::CFG_W-1:0] tiles_cfg,
  input  logic                       out_ready,
  output logic                       out_valid,
  output kdme_pkg::out_t             out_data,
  input  kdme_pkg::cmd_t             cmd,
  output kdme_pkg::stat_t            stat
);

  localparam int POS_W     = $clog2(MAX_TILES);
  localparam int LEN_W     = $clog2(MAX_TILES + 1);
  localparam int CW        = LEN_W + 1;
  localparam int MAX_BYTES = (MAX_TILES + 7) / 8;
  localparam int MASK_W    = MAX_BYTES * 8;
  localparam int BYTE_W    = $clog2(MAX_BYTES + 1);
  localparam int BIDX_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int ADDR_W    = $clog2(MAX_MASKS);
  localparam int CNT_W     = $clog2(MAX_MASKS + 1);

  logic [kdme_pkg::TILE_W-1:0] kf_mem [MAX_TILES];
  logic [MASK_W-1:0]           tbl_mem [MAX_MASKS];

  logic [kdme_pkg::TILE_W-1:0] kf_q_r;
  logic [MASK_W-1:0]           tbl_q_r;
  logic [kdme_pkg::TILE_W-1:0] tile_r;
  logic [POS_W-1:0]            cur_pos_r;
  logic                        fend_r;
  logic                        capt_item_r;
  logic [BYTE_W-1:0]           nbytes_r;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              capt_r, capt_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              out_valid_r, out_valid_nxt;
  kdme_pkg::out_t    out_data_r;

  logic [kdme_pkg::CFG_W-1:0] len7;
  logic [LEN_W-1:0]           len;
  logic                       capt_eff;
  logic [POS_W-1:0]           pos_eff;
  logic [CW-1:0]              pos_inc;
  logic                       fend;
  logic [CW-1:0]              len_sum;
  logic [kdme_pkg::VALUE_W-1:0] value_sel;

  // clamp the frame length into one to MAX_TILES
  always_comb begin
    if (tiles_cfg == '0) begin
      len7 = 7'd1;
    end else if (tiles_cfg > 7'(MAX_TILES)) begin
      len7 = 7'(MAX_TILES);
    end else begin
      len7 = tiles_cfg;
    end
    len      = LEN_W'(len7);
    capt_eff = in_data.restart | capt_r;
    pos_eff  = in_data.restart ? '0 : pos_r;
    pos_inc  = CW'(pos_eff) + CW'(1);
    fend     = (pos_inc >= CW'(len));
    len_sum  = CW'(len) + CW'(7);
  end

  // key frame store; read and write share the address of the accepted tile
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (capt_eff) begin
        kf_mem[pos_eff] <= in_data.tile;
      end
      kf_q_r      <= kf_mem[pos_eff];
      tile_r      <= in_data.tile;
      cur_pos_r   <= pos_eff;
      fend_r      <= fend;
      capt_item_r <= capt_eff;
      nbytes_r    <= BYTE_W'(len_sum >> 3);
    end
  end

  // mask table
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      tbl_mem[count_r[ADDR_W-1:0]] <= mask_r;
    end
    if (cmd.tbl_rd) begin
      tbl_q_r <= tbl_mem[idx_r[ADDR_W-1:0]];
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    capt_nxt  = capt_r;
    mask_nxt  = mask_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    byte_nxt  = byte_r;
    if (cmd.take) begin
      pos_nxt  = fend ? '0 : POS_W'(pos_inc);
      capt_nxt = capt_eff & !fend;
      idx_nxt  = '0;
      byte_nxt = '0;
      if (in_data.restart) begin
        mask_nxt  = '0;
        count_nxt = '0;
      end
    end
    if (cmd.mark) begin
      mask_nxt[cur_pos_r] = 1'b1;
    end
    if (cmd.idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
    if (cmd.store) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.byte_inc) begin
      byte_nxt = byte_r + BYTE_W'(1);
    end
    if (cmd.clr_mask) begin
      mask_nxt = '0;
    end
  end

  always_comb begin
    case (cmd.kind)
      kdme_pkg::KIND_TILE:  value_sel = tile_r;
      kdme_pkg::KIND_KNOWN: value_sel = 8'(idx_r);
      kdme_pkg::KIND_NEW:   value_sel = 8'(count_r);
      kdme_pkg::KIND_BYTE:  value_sel = mask_r[{byte_r[BIDX_W-1:0], 3'b000} +: 8];
      default:              value_sel = '0;
    endcase
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      capt_r      <= 1'b1;
      mask_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      byte_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      capt_r      <= capt_nxt;
      mask_r      <= mask_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      byte_r      <= byte_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.kind  <= cmd.kind;
      out_data_r.value <= value_sel;
      out_data_r.last  <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat.capt      = capt_item_r;
    stat.diff      = (tile_r != kf_q_r);
    stat.fend      = fend_r;
    stat.scan_end  = (idx_r == count_r);
    stat.hit       = (tbl_q_r == mask_r);
    stat.full      = (count_r == CNT_W'(MAX_MASKS));
    stat.byte_last = (BYTE_W'(byte_r + BYTE_W'(1)) == nbytes_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

endmodule

FILE: design/keyframe_delta_mask_encoder.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_data  (tile, restart)
// out_      output     out_valid / out_ready  out_data (kind, value, last)
// cfg_      input      APB, pready tied high  tiles_per_frame at byte address 0
//
// A tile takes a key frame read and then a compare; a changed tile also loads
// its result. On the last tile of a frame each stored mask is read from the table
// and compared, plus a final check when none of them matches, then each result
// waits for a free output slot; a new mask adds its index and up to eight bytes.
// Reset is synchronous, active low; the stores need no clearing pass. A stalled
// output holds the controller: no request is taken until its last result is loaded.
module keyframe_delta_mask_encoder #(
  parameter int MAX_TILES = 64,
  parameter int MAX_MASKS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kdme_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kdme_pkg::out_t out_data,
  input  logic           cfg_psel,
  input  logic           cfg_penable,
  input  logic           cfg_pwrite,
  input  logic [2:0]     cfg_paddr,
  input  logic [31:0]    cfg_pwdata,
  output logic [31:0]    cfg_prdata,
  output logic           cfg_pready
);

  logic [kdme_pkg::CFG_W-1:0] tiles_r, tiles_nxt;
  kdme_pkg::cmd_t             cmd;
  kdme_pkg::stat_t            stat;

  always_comb begin
    tiles_nxt = tiles_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == kdme_pkg::REG_TILES)) begin
      tiles_nxt = cfg_pwdata[kdme_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiles_r <= kdme_pkg::TILES_RESET;
    end else begin
      tiles_r <= tiles_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == kdme_pkg::REG_TILES) ? 32'(tiles_r) : '0;

  kdme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kdme_dp #(
    .MAX_TILES (MAX_TILES),
    .MAX_MASKS (MAX_MASKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .tiles_cfg (tiles_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: tb/keyframe_delta_mask_encoder_tb.sv
`timescale 1ns / 100ps

module keyframe_delta_mask_encoder_tb;

  localparam int TILE_SLOTS    = 64;
  localparam int MASK_SLOTS    = 32;
  localparam int SETTLE_CYCLES = 2 * MASK_SLOTS + 16;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 40;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  kdme_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  kdme_pkg::out_t out_data;
  logic           cfg_psel = 1'b0;
  logic           cfg_penable = 1'b0;
  logic           cfg_pwrite = 1'b0;
  logic [2:0]     cfg_paddr = '0;
  logic [31:0]    cfg_pwdata = '0;
  logic [31:0]    cfg_prdata;
  logic           cfg_pready;

  // encoder state mirrored on the bench side
  logic [6:0]  tiles_cfg = kdme_pkg::TILES_RESET;
  bit [7:0]    key_tiles [TILE_SLOTS];
  bit          key_written [TILE_SLOTS];
  logic [63:0] change_bits = '0;
  int unsigned position = 0;
  bit          capturing = 1'b1;
  logic [63:0] seen_masks [MASK_SLOTS];
  int unsigned mask_total = 0;

  kdme_pkg::out_t owed_symbols [$];
  int unsigned    error_count = 0;
  int unsigned    stall_cycles = 0;
  bit             quiet = 1'b0;
  bit             force_restart = 1'b0;

  keyframe_delta_mask_encoder #(
    .MAX_TILES(TILE_SLOTS),
    .MAX_MASKS(MASK_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic int unsigned frame_length();
    int unsigned n;
    n = tiles_cfg;
    if (n == 0) n = 1;
    if (n > TILE_SLOTS) n = TILE_SLOTS;
    return n;
  endfunction

  function automatic void encode_tile(kdme_pkg::in_t req);
    kdme_pkg::out_t batch [10];
    int unsigned    n, pos, nbytes, hit, cnt, i;
    bit             frame_end, found;
    n = frame_length();
    cnt = 0;
    hit = 0;
    found = 1'b0;
    if (req.restart) begin
      capturing = 1'b1;
      position = 0;
      change_bits = '0;
      mask_total = 0;
    end
    pos = (position >= TILE_SLOTS) ? TILE_SLOTS - 1 : position;
    frame_end = (pos + 1 >= n);
    if (capturing) begin
      key_tiles[pos] = req.tile;
      key_written[pos] = 1'b1;
      if (frame_end) capturing = 1'b0;
    end else begin
      if (req.tile != key_tiles[pos]) begin
        batch[cnt] = '{kind: kdme_pkg::KIND_TILE, value: req.tile, last: 1'b0};
        cnt++;
        change_bits[pos] = 1'b1;
      end
      if (frame_end) begin
        for (i = 0; i < mask_total; i++) begin
          if (!found && seen_masks[i] == change_bits) begin
            found = 1'b1;
            hit = i;
          end
        end
        if (found) begin
          batch[cnt] = '{kind: kdme_pkg::KIND_KNOWN, value: 8'(hit), last: 1'b0};
          cnt++;
        end else if (mask_total < MASK_SLOTS) begin
          seen_masks[mask_total] = change_bits;
          batch[cnt] = '{kind: kdme_pkg::KIND_NEW, value: 8'(mask_total), last: 1'b0};
          cnt++;
          mask_total++;
          nbytes = (n + 7) / 8;
          for (i = 0; i < nbytes; i++) begin
            batch[cnt] = '{kind: kdme_pkg::KIND_BYTE, value: change_bits[8*i +: 8],
                           last: 1'b0};
            cnt++;
          end
        end else begin
          // table full: drop the mask
          batch[cnt] = '{kind: kdme_pkg::KIND_FULL, value: 8'h00, last: 1'b0};
          cnt++;
        end
        change_bits = '0;
      end
    end
    position = frame_end ? 0 : pos + 1;
    if (cnt > 0) batch[cnt-1].last = 1'b1;
    for (i = 0; i < cnt; i++) owed_symbols.push_back(batch[i]);
  endfunction

  // tile for the next request: a fresh value while capturing, else mostly the key tile
  function automatic logic [7:0] pick_tile(input bit restart, input int unsigned change_pct);
    int unsigned pos;
    pos = (position >= TILE_SLOTS) ? TILE_SLOTS - 1 : position;
    if (restart || capturing || $urandom_range(99) < change_pct) return 8'($urandom);
    return key_tiles[pos];
  endfunction

  task automatic send_request(input logic [7:0] tile, input bit restart);
    if (force_restart) begin
      restart = 1'b1;
      force_restart = 1'b0;
    end
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{tile: tile, restart: restart};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_tile('{tile: tile, restart: restart});
  endtask

  // finish the current frame, flipping the tiles whose mask bit is set
  task automatic send_masked_frame(input logic [63:0] bits);
    int unsigned pos;
    do begin
      pos = (position >= TILE_SLOTS) ? TILE_SLOTS - 1 : position;
      if (capturing) send_request(8'($urandom), 1'b0);
      else send_request(bits[pos] ? ~key_tiles[pos] : key_tiles[pos], 1'b0);
    end while (position != 0);
  endtask

  task automatic start_picture();
    send_request(8'($urandom), 1'b1);
    while (position != 0) send_request(8'($urandom), 1'b0);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (owed_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_length(input logic [6:0] n);
    int unsigned i;
    bit          covered;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * int'(kdme_pkg::REG_TILES));
    cfg_pwdata <= 32'(n);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tiles_cfg = n;
    // never let a longer frame read key tiles that were never captured
    covered = 1'b1;
    for (i = 0; i < frame_length(); i++) if (!key_written[i]) covered = 1'b0;
    if (!capturing && !covered) force_restart = 1'b1;
  endtask

  task automatic test_directed_frames();
    bit [7:0] key_pattern [4];
    bit [7:0] flipped [4];
    key_pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    flipped = '{8'hFF, 8'h00, 8'hAA, 8'h55};
    write_frame_length(7'd4);
    foreach (key_pattern[i]) send_request(key_pattern[i], i == 0);
    foreach (key_pattern[i]) send_request(key_pattern[i], 1'b0);
    foreach (flipped[i]) send_request(flipped[i], 1'b0);
    foreach (key_pattern[i]) send_request(key_pattern[i], 1'b0);
    // restart on the second tile of a frame
    send_request(8'h00, 1'b0);
    send_request(8'h12, 1'b1);
    send_request(8'h34, 1'b0);
    send_request(8'h56, 1'b0);
    send_request(8'h78, 1'b0);
    send_request(8'h12, 1'b0);
    send_request(8'h35, 1'b0);
    send_request(8'h56, 1'b0);
    send_request(8'h78, 1'b0);
  endtask

  task automatic test_frame_lengths();
    logic [7:0] first;
    wait_for_drain();
    write_frame_length(7'd0);
    start_picture();
    first = key_tiles[0];
    send_request(first, 1'b0);
    send_request(~first, 1'b0);
    send_request(~first, 1'b0);
    send_request(first, 1'b0);
    wait_for_drain();
    write_frame_length(7'd127);
    start_picture();
    // two changed tiles, the last one bringing the longest burst of results
    send_masked_frame(64'h8000_0000_0000_0001);
    wait_for_drain();
    write_frame_length(7'd9);
    send_masked_frame(64'h1);
    send_masked_frame(64'h100);
    wait_for_drain();
    write_frame_length(7'd8);
    send_masked_frame(64'h1);
    repeat (3) send_request(key_tiles[position], 1'b0);
    // shrink the frame part way through
    wait_for_drain();
    write_frame_length(7'd2);
    send_masked_frame(64'h8);
    wait_for_drain();
    write_frame_length(7'd20);
    send_masked_frame(64'h000F_0F0F);
  endtask

  task automatic test_table_overflow();
    int unsigned f;
    wait_for_drain();
    write_frame_length(7'd6);
    start_picture();
    // run part of the fill with no idling on either side
    for (f = 1; f <= 33; f++) begin
      quiet = (f >= 8 && f <= 24);
      send_masked_frame(64'(6'(f * 37)));
    end
    quiet = 1'b0;
    send_masked_frame(64'(6'(5 * 37)));
    send_masked_frame('0);
    start_picture();
    send_masked_frame(64'h7);
  endtask

  task automatic test_random_traffic();
    int unsigned sent, seg_len, pct, k;
    logic [6:0]  len;
    bit          restart;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: len = 7'd0;
        1: len = 7'($urandom_range(65, 127));
        2, 3: len = 7'($urandom_range(13, 64));
        default: len = 7'($urandom_range(1, 12));
      endcase
      wait_for_drain();
      write_frame_length(len);
      seg_len = $urandom_range(10, 30);
      pct = $urandom_range(0, 35);
      for (k = 0; k < seg_len; k++) begin
        restart = (k == 0 && $urandom_range(2) == 0) || $urandom_range(99) < 2;
        send_request(pick_tile(restart || force_restart, pct), restart);
        sent++;
      end
    end
  endtask

  always @(posedge clk) out_ready <= quiet || ($urandom_range(99) >= 19);

  always @(posedge clk) begin : result_check
    kdme_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_symbols.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: kind=%0d value=%02h last=%0b",
                   out_data.kind, out_data.value, out_data.last);
      end else begin
        want = owed_symbols.pop_front();
        if (out_data.kind !== want.kind || out_data.value !== want.value ||
            out_data.last !== want.last) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected kind=%0d value=%02h last=%0b,",
                     want.kind, want.value, want.last,
                     " got kind=%0d value=%02h last=%0b",
                     out_data.kind, out_data.value, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("keyframe_delta_mask_encoder_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_frame_lengths();
    test_table_overflow();
    test_random_traffic();
    wait_for_drain();
    if (error_count == 0 && owed_symbols.size() == 0) begin
      $display("keyframe_delta_mask_encoder_tb passed");
    end else begin
      $display("keyframe_delta_mask_encoder_tb failed");
    end
    $finish;
  end

endmodule
